@@ design/tcs_pkg.sv @@
// Shared types and mode codes for the tray carousel sequencer.
// Depends on nothing; used by tcs_step and tray_carousel_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

  localparam int TIMEOUT_BITS = 20;
  localparam int TRAY_BITS    = 8;
  localparam int MODE_BITS    = 3;

  localparam logic [MODE_BITS-1:0] MODE_HOMING = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_IDLE   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_MOVING = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_SERVO  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_WOPEN  = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_WCLOSE = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_ERROR  = 3'd6;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 20'd10000;
  localparam logic [TRAY_BITS-1:0]    TRAY_MAX      = 8'hFF;

  typedef struct packed {
    logic                 move_request;
    logic [TRAY_BITS-1:0] target_tray;
    logic                 home_pressed;
    logic                 tray_pulse;
    logic                 servo_pressed;
    logic                 door_pressed;
  } tick_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode_code;
    logic                 motor_run;
    logic                 servo_open;
    logic [TRAY_BITS-1:0] tray_count;
    logic                 is_idle;
    logic                 is_error;
  } result_t;

endpackage

`default_nettype wire

@@ design/tcs_step.sv @@
// Next-state and result logic for one tick of the sequencer.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcs_step
  import tcs_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  wire tick_t                    tick,
  input  wire logic [TIMEOUT_BITS-1:0]  move_timeout,
  input  wire logic [MODE_BITS-1:0]     mode,
  input  wire logic [TRAY_BITS-1:0]     count,
  input  wire logic [TRAY_BITS-1:0]     destination,
  input  wire logic [TIMER_BITS-1:0]    elapsed,
  input  wire logic                     servo_state,
  output logic      [MODE_BITS-1:0]     mode_next,
  output logic      [TRAY_BITS-1:0]     count_next,
  output logic      [TRAY_BITS-1:0]     destination_next,
  output logic      [TIMER_BITS-1:0]    elapsed_next,
  output logic                          servo_state_next,
  output result_t                       result
);

  localparam int CMP_BITS = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;
  localparam logic [TIMER_BITS-1:0] ELAPSED_MAX = {TIMER_BITS{1'b1}};

  logic [MODE_BITS-1:0]  mode_entry;
  logic                  timed_out;
  logic                  request_taken;
  logic [TIMER_BITS-1:0] elapsed_entry;

  // The timeout test looks at the elapsed count after a possible request restart.
  assign request_taken = (mode == MODE_IDLE) && tick.move_request;
  assign elapsed_entry = request_taken ? '0 : elapsed;
  assign timed_out     = CMP_BITS'(elapsed_entry) > CMP_BITS'(move_timeout);

  always_comb begin
    mode_next        = mode;
    count_next       = count;
    destination_next = destination;
    elapsed_next     = elapsed;
    servo_state_next = servo_state;

    if (mode == MODE_IDLE && tick.move_request) begin
      destination_next = tick.target_tray;
      mode_next        = MODE_MOVING;
      elapsed_next     = '0;
    end
    mode_entry = mode_next;

    case (mode_entry)
      MODE_HOMING: begin
        if (timed_out) begin
          mode_next = MODE_ERROR;
        end else begin
          if (elapsed_next != ELAPSED_MAX) elapsed_next = elapsed_next + 1'b1;
          if (tick.home_pressed) begin
            count_next = '0;
            mode_next  = MODE_IDLE;
          end
        end
      end
      MODE_IDLE: begin
      end
      MODE_MOVING: begin
        if (timed_out) begin
          mode_next = MODE_ERROR;
        end else begin
          if (elapsed_next != ELAPSED_MAX) elapsed_next = elapsed_next + 1'b1;
          if (tick.home_pressed) count_next = '0;
          if (tick.tray_pulse) begin
            if (count_next != TRAY_MAX) count_next = count_next + 1'b1;
            if (count_next == destination_next) mode_next = MODE_SERVO;
          end
        end
      end
      MODE_SERVO: begin
        servo_state_next = 1'b1;
        if (!tick.servo_pressed) mode_next = MODE_WOPEN;
      end
      MODE_WOPEN: begin
        if (!tick.door_pressed) mode_next = MODE_WCLOSE;
      end
      MODE_WCLOSE: begin
        if (tick.door_pressed) begin
          servo_state_next = 1'b0;
          mode_next        = MODE_HOMING;
          elapsed_next     = '0;
        end
      end
      default: begin
        mode_next = MODE_ERROR;
      end
    endcase
  end

  always_comb begin
    result.mode_code  = mode_next;
    result.motor_run  = (mode_next == MODE_HOMING) || (mode_next == MODE_MOVING);
    result.servo_open = servo_state_next;
    result.tray_count = count_next;
    result.is_idle    = (mode_next == MODE_IDLE);
    result.is_error   = (mode_next == MODE_ERROR);
  end

endmodule

`default_nettype wire

@@ design/tray_carousel_sequencer.sv @@
// Tray carousel sequencer: one tick request in, one status request out.
// Each accepted tick is held in the input register, then the state update writes the result register;
// one request per cycle sustained while out_stall does not hold a valid result.
// Synchronous active-high reset returns the machine to homing, clears counters and
// restores the timeout register to 10000 ticks.
// Depends on tcs_pkg and tcs_step.
`timescale 1ns / 1ps
`default_nettype none

module tray_carousel_sequencer
  import tcs_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [TIMEOUT_BITS-1:0] cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    move_request,
  input  wire logic [TRAY_BITS-1:0]    target_tray,
  input  wire logic                    home_pressed,
  input  wire logic                    tray_pulse,
  input  wire logic                    servo_pressed,
  input  wire logic                    door_pressed,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [MODE_BITS-1:0]         mode_code,
  output logic                         motor_run,
  output logic                         servo_open,
  output logic [TRAY_BITS-1:0]         tray_count,
  output logic                         is_idle,
  output logic                         is_error
);

  logic [TIMEOUT_BITS-1:0] move_timeout;
  logic [MODE_BITS-1:0]    mode;
  logic [MODE_BITS-1:0]    mode_next;
  logic [TRAY_BITS-1:0]    count;
  logic [TRAY_BITS-1:0]    count_next;
  logic [TRAY_BITS-1:0]    destination;
  logic [TRAY_BITS-1:0]    destination_next;
  logic [TIMER_BITS-1:0]   elapsed;
  logic [TIMER_BITS-1:0]   elapsed_next;
  logic                    servo_state;
  logic                    servo_state_next;

  logic    tick_valid;
  tick_t   tick;
  result_t step_result;
  result_t result;
  logic    advance;

  // A held tick moves to the result register whenever that register is free or draining.
  assign advance  = tick_valid && !(out_valid && out_stall);
  assign in_stall = tick_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      move_timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      tick.move_request  <= move_request;
      tick.target_tray   <= target_tray;
      tick.home_pressed  <= home_pressed;
      tick.tray_pulse    <= tray_pulse;
      tick.servo_pressed <= servo_pressed;
      tick.door_pressed  <= door_pressed;
    end
  end

  tcs_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .tick            (tick),
    .move_timeout    (move_timeout),
    .mode            (mode),
    .count           (count),
    .destination     (destination),
    .elapsed         (elapsed),
    .servo_state     (servo_state),
    .mode_next       (mode_next),
    .count_next      (count_next),
    .destination_next(destination_next),
    .elapsed_next    (elapsed_next),
    .servo_state_next(servo_state_next),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_HOMING;
      count       <= '0;
      destination <= '0;
      elapsed     <= '0;
      servo_state <= 1'b0;
    end else if (advance) begin
      mode        <= mode_next;
      count       <= count_next;
      destination <= destination_next;
      elapsed     <= elapsed_next;
      servo_state <= servo_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign mode_code  = result.mode_code;
  assign motor_run  = result.motor_run;
  assign servo_open = result.servo_open;
  assign tray_count = result.tray_count;
  assign is_idle    = result.is_idle;
  assign is_error   = result.is_error;

endmodule

`default_nettype wire

@@ test/tray_carousel_sequencer_tb.sv @@
// Self-checking testbench for tray_carousel_sequencer: tick requests in, status out.
// Depends on tcs_pkg and the design files; a scoreboard class predicts every status.
`timescale 1ns / 1ps

module tray_carousel_sequencer_tb;
  import tcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;
  localparam int PHASE_TICKS    = 100;

  class sequencer_scoreboard;
    logic [TIMEOUT_BITS-1:0] timeout;
    logic [MODE_BITS-1:0]    mode;
    logic [TRAY_BITS-1:0]    count;
    logic [TRAY_BITS-1:0]    dest;
    logic [TIMEOUT_BITS-1:0] elapsed;
    logic                    servo;
    result_t                 expected_status[$];
    int                      errors;
    int                      status_index;

    function new();
      timeout      = TIMEOUT_RESET;
      mode         = MODE_HOMING;
      count        = '0;
      dest         = '0;
      elapsed      = '0;
      servo        = 1'b0;
      errors       = 0;
      status_index = 0;
    endfunction

    // Returns 1 when the homing or moving timeout fires this tick.
    function bit timer_tripped();
      if (elapsed > timeout) begin
        mode = MODE_ERROR;
        return 1'b1;
      end
      if (elapsed != '1) elapsed++;
      return 1'b0;
    endfunction

    function void note_tick(tick_t t);
      result_t r;
      if (mode == MODE_IDLE && t.move_request) begin
        dest    = t.target_tray;
        mode    = MODE_MOVING;
        elapsed = '0;
      end
      case (mode)
        MODE_HOMING: begin
          if (!timer_tripped() && t.home_pressed) begin
            count = '0;
            mode  = MODE_IDLE;
          end
        end
        MODE_IDLE: ;
        MODE_MOVING: begin
          if (!timer_tripped()) begin
            if (t.home_pressed) count = '0;
            if (t.tray_pulse) begin
              if (count != TRAY_MAX) count++;
              if (count == dest) mode = MODE_SERVO;
            end
          end
        end
        MODE_SERVO: begin
          servo = 1'b1;
          if (!t.servo_pressed) mode = MODE_WOPEN;
        end
        MODE_WOPEN: begin
          if (!t.door_pressed) mode = MODE_WCLOSE;
        end
        MODE_WCLOSE: begin
          if (t.door_pressed) begin
            servo   = 1'b0;
            mode    = MODE_HOMING;
            elapsed = '0;
          end
        end
        default: mode = MODE_ERROR;
      endcase
      r.mode_code  = mode;
      r.motor_run  = (mode == MODE_HOMING) || (mode == MODE_MOVING);
      r.servo_open = servo;
      r.tray_count = count;
      r.is_idle    = (mode == MODE_IDLE);
      r.is_error   = (mode == MODE_ERROR);
      expected_status.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH status %0d: %s", status_index, msg);
    endtask

    task check_status(result_t got);
      result_t want;
      if (expected_status.size() == 0) begin
        report("status arrived with no request outstanding");
        return;
      end
      want = expected_status.pop_front();
      if (got.mode_code !== want.mode_code)
        report($sformatf("mode_code got %0d expected %0d", got.mode_code, want.mode_code));
      if (got.motor_run !== want.motor_run)
        report($sformatf("motor_run got %0b expected %0b", got.motor_run, want.motor_run));
      if (got.servo_open !== want.servo_open)
        report($sformatf("servo_open got %0b expected %0b", got.servo_open, want.servo_open));
      if (got.tray_count !== want.tray_count)
        report($sformatf("tray_count got %0d expected %0d", got.tray_count, want.tray_count));
      if (got.is_idle !== want.is_idle)
        report($sformatf("is_idle got %0b expected %0b", got.is_idle, want.is_idle));
      if (got.is_error !== want.is_error)
        report($sformatf("is_error got %0b expected %0b", got.is_error, want.is_error));
      status_index++;
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [TIMEOUT_BITS-1:0] cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    move_request;
  logic [TRAY_BITS-1:0]    target_tray;
  logic                    home_pressed;
  logic                    tray_pulse;
  logic                    servo_pressed;
  logic                    door_pressed;
  logic                    out_valid;
  logic                    out_stall;
  logic [MODE_BITS-1:0]    mode_code;
  logic                    motor_run;
  logic                    servo_open;
  logic [TRAY_BITS-1:0]    tray_count;
  logic                    is_idle;
  logic                    is_error;

  sequencer_scoreboard sb;
  bit send_gaps;
  bit recv_gaps;
  bit hold_pending;
  int quiet_cycles;

  tray_carousel_sequencer #(
    .TIMER_BITS(20)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .move_request (move_request),
    .target_tray  (target_tray),
    .home_pressed (home_pressed),
    .tray_pulse   (tray_pulse),
    .servo_pressed(servo_pressed),
    .door_pressed (door_pressed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mode_code    (mode_code),
    .motor_run    (motor_run),
    .servo_open   (servo_open),
    .tray_count   (tray_count),
    .is_idle      (is_idle),
    .is_error     (is_error)
  );

  always #6 clk = ~clk;

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random tick content, shaped by the predicted state so that the run keeps
  // clear of the error state. With steer set, it pushes the machine toward idle.
  function automatic tick_t next_tick(bit steer);
    logic [31:0] raw;
    tick_t t;
    int    lim;
    int    el;
    int    cnt;
    int    dst;
    int    budget;
    raw = $urandom;
    t   = raw[$bits(tick_t)-1:0];
    case (sb.mode)
      MODE_HOMING: begin
        if (steer || sb.elapsed >= sb.timeout) t.home_pressed = 1'b1;
      end
      MODE_IDLE: begin
        t.move_request = !steer && ($urandom_range(0, 3) != 0);
        if (t.move_request) begin
          lim = int'(sb.timeout) + 1;
          if (lim > 255) lim = 255;
          if ($urandom_range(0, 29) == 0) t.target_tray = TRAY_BITS'($urandom_range(1, lim));
          else t.target_tray = TRAY_BITS'($urandom_range(1, (lim < 12) ? lim : 12));
        end
      end
      MODE_SERVO:  if (steer) t.servo_pressed = 1'b0;
      MODE_WOPEN:  if (steer) t.door_pressed = 1'b0;
      MODE_WCLOSE: if (steer) t.door_pressed = 1'b1;
      default: ;
    endcase
    if (sb.mode == MODE_MOVING || (sb.mode == MODE_IDLE && t.move_request)) begin
      el     = (sb.mode == MODE_MOVING) ? int'(sb.elapsed) : 0;
      cnt    = (sb.mode == MODE_MOVING) ? int'(sb.count) : 0;
      dst    = (sb.mode == MODE_MOVING) ? int'(sb.dest) : int'(t.target_tray);
      // Ticks left before the timeout fires, this one included.
      budget = int'(sb.timeout) - el + 1;
      if (steer || dst - cnt >= budget) begin
        t.tray_pulse   = 1'b1;
        t.home_pressed = 1'b0;
      end else begin
        t.tray_pulse   = $urandom_range(0, 9) < 6;
        t.home_pressed = (budget > dst + 1) && ($urandom_range(0, 15) == 0);
      end
    end
    return t;
  endfunction

  task automatic offer(input tick_t t);
    int gap;
    in_valid <= 1'b1;
    {move_request, target_tray, home_pressed, tray_pulse, servo_pressed, door_pressed} <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_tick(t);
    gap = pick_gap(send_gaps);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_fields(input bit req, input int tgt, input bit home, input bit pulse,
                              input bit servo_sw, input bit door);
    tick_t t;
    t.move_request  = req;
    t.target_tray   = TRAY_BITS'(tgt);
    t.home_pressed  = home;
    t.tray_pulse    = pulse;
    t.servo_pressed = servo_sw;
    t.door_pressed  = door;
    offer(t);
  endtask

  // Bring the machine back to idle and wait until every status has come back.
  task automatic settle_idle();
    while (sb.mode != MODE_IDLE) offer(next_tick(1'b1));
    in_valid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_BITS-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.timeout = value;
  endtask

  initial begin
    int gap;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        // Long hold-off so that the block fills up and stalls its input.
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        gap = pick_gap(recv_gaps);
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.mode_code  = mode_code;
      got.motor_run  = motor_run;
      got.servo_open = servo_open;
      got.tray_count = tray_count;
      got.is_idle    = is_idle;
      got.is_error   = is_error;
      sb.check_status(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tray_carousel_sequencer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TIMEOUT_BITS-1:0] limits[5];
    sb           = new();
    send_gaps    = 1'b1;
    recv_gaps    = 1'b1;
    hold_pending = 1'b0;
    quiet_cycles = 0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    move_request  <= 1'b0;
    target_tray   <= '0;
    home_pressed  <= 1'b0;
    tray_pulse    <= 1'b0;
    servo_pressed <= 1'b0;
    door_pressed  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every state but the error state with the reset timeout.
    offer_fields(0,   0, 0, 0, 0, 0);
    offer_fields(1, 255, 0, 1, 1, 1);  // request while homing is ignored
    offer_fields(0,   0, 1, 0, 0, 0);
    offer_fields(0,   0, 1, 1, 1, 1);
    offer_fields(1,   2, 1, 1, 0, 0);  // home clears the count, then the pulse counts
    offer_fields(0,   0, 0, 0, 0, 0);
    offer_fields(1, 255, 0, 1, 1, 1);  // target reached; request ignored
    offer_fields(0,   0, 0, 0, 1, 1);
    offer_fields(0,   0, 0, 0, 0, 1);
    offer_fields(0,   0, 0, 0, 0, 1);
    offer_fields(0,   0, 0, 0, 0, 0);
    offer_fields(1, 128, 0, 0, 0, 0);
    offer_fields(0,   0, 0, 0, 0, 1);
    offer_fields(0,   0, 1, 0, 0, 0);
    offer_fields(1,   1, 0, 1, 0, 0);  // target one is reached on the request tick
    offer_fields(0,   0, 0, 0, 0, 0);
    offer_fields(0,   0, 0, 0, 0, 0);
    offer_fields(0,   0, 0, 0, 0, 1);
    offer_fields(0,   0, 1, 0, 0, 0);
    offer_fields(1,   3, 0, 1, 0, 0);
    offer_fields(0,   0, 1, 0, 0, 0);  // home while moving drops the count to zero
    settle_idle();

    limits[0] = 20'd1;
    limits[1] = 20'hFFFFF;
    limits[2] = 20'd4;
    limits[3] = 20'd30;
    limits[4] = TIMEOUT_BITS'($urandom_range(2, 200));
    for (int p = 0; p < 5; p++) begin
      send_gaps = (p != 1) && (p != 3);
      recv_gaps = (p != 3);
      if (p == 1) hold_pending = 1'b1;
      write_timeout(limits[p]);
      repeat (PHASE_TICKS) offer(next_tick(1'b0));
      settle_idle();
    end

    // A zero target is never matched: the count saturates, then the timeout
    // latches the error state, which ignores everything afterward.
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    write_timeout(20'd280);
    offer_fields(1, 0, 0, 1, 0, 0);
    while (sb.mode != MODE_ERROR)
      offer_fields(1'($urandom_range(0, 1)), int'($urandom_range(0, 255)), 0, 1, 1, 1);
    repeat (20) offer(next_tick(1'b0));
    in_valid <= 1'b0;

    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tray_carousel_sequencer regression: pass");
    end else begin
      $display("tray_carousel_sequencer regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tcs_pkg.sv
design/tcs_step.sv
design/tray_carousel_sequencer.sv
test/tray_carousel_sequencer_tb.sv
